[design/drrs_pkg.sv]
// Package for the distance resample and run segmenter.
// Holds register codes, reset values, controller states and command/status structs.
package drrs_pkg;

   localparam int MAX_POINTS_DEFAULT = 16;
   localparam int INDEX_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_STEP_LENGTH = 2'd0,
      REG_SENSITIVITY = 2'd1,
      REG_MIN_Y       = 2'd2,
      REG_MAX_Y       = 2'd3
   } reg_index_type;

   localparam logic [15:0]        RESET_STEP_LENGTH = 16'd100;
   localparam logic [15:0]        RESET_SENSITIVITY = 16'd0;
   localparam logic signed [15:0] RESET_MIN_Y       = -16'sd32768;
   localparam logic signed [15:0] RESET_MAX_Y       = 16'sd32767;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic load_item;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic have_step;
      logic last;
   } status_type;

endpackage

[design/drrs_if.sv]
// Channel interfaces for the distance resample and run segmenter.
// Request channel carries one input item, response channel one resampled point.
interface drrs_req_if;
   logic              valid;
   logic              ready;
   logic [15:0]       delta_x;
   logic signed [15:0] sample_y;

   modport source (output valid, delta_x, sample_y, input ready);
   modport sink (input valid, delta_x, sample_y, output ready);
endinterface

interface drrs_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        point_index;
   logic signed [15:0] point_y;
   logic               segment_valid;
   logic [15:0]        segment_start;
   logic [15:0]        segment_end;
   logic signed [15:0] segment_level;
   logic               backlog;
   logic               last_of_run;

   modport source (output valid, point_index, point_y, segment_valid, segment_start,
                   segment_end, segment_level, backlog, last_of_run, input ready);
   modport sink (input valid, point_index, point_y, segment_valid, segment_start,
                 segment_end, segment_level, backlog, last_of_run, output ready);
endinterface

[design/drrs_ctrl.sv]
// Controller state machine for the distance resample and run segmenter.
// Depends on drrs_pkg for states and the command/status structs.
module drrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  drrs_pkg::status_type sts,
   output drrs_pkg::cmd_type    cmd
);

   drrs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drrs_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = drrs_pkg::S_EMIT;
            end
         end
         drrs_pkg::S_EMIT: begin
            if (!sts.have_step) begin
               state_in = drrs_pkg::S_IDLE;
            end else if (slot_free && sts.last) begin
               state_in = drrs_pkg::S_IDLE;
            end
         end
         default: state_in = drrs_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.emit      = 1'b0;
      case (state_ff)
         drrs_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         drrs_pkg::S_EMIT: begin
            cmd.emit = sts.have_step && slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drrs_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_needs_step: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.have_step)
      else $error("point emitted without a whole step in the accumulator");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && sts.last |=> state_ff == drrs_pkg::S_IDLE)
      else $error("controller kept emitting after the last point");

   a_load_starts_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == drrs_pkg::S_EMIT && rsp_valid_ff == $past(rsp_valid_in))
      else $error("accepted request did not start emission");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !cmd.emit)
      else $error("pending point overwritten");

endmodule

[design/drrs_datapath.sv]
// Datapath for the distance resample and run segmenter: configuration, accumulator,
// clamp, run tracking and the response register. Depends on drrs_pkg.
module drrs_datapath #(
   parameter int MAX_POINTS_PER_ITEM = drrs_pkg::MAX_POINTS_DEFAULT,
   parameter int INDEX_BITS          = drrs_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [drrs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [drrs_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic [15:0]                          req_delta_x,
   input  logic signed [15:0]                   req_sample_y,
   input  drrs_pkg::cmd_type                     cmd,
   output drrs_pkg::status_type                  sts,
   output logic [15:0]                          rsp_point_index,
   output logic signed [15:0]                   rsp_point_y,
   output logic                                 rsp_segment_valid,
   output logic [15:0]                          rsp_segment_start,
   output logic [15:0]                          rsp_segment_end,
   output logic signed [15:0]                   rsp_segment_level,
   output logic                                 rsp_backlog,
   output logic                                 rsp_last_of_run
);

   localparam int CNT_BITS  = $clog2(MAX_POINTS_PER_ITEM + 1);
   localparam int CAP_BITS  = 16 + $clog2(MAX_POINTS_PER_ITEM + 2);
   localparam int WIDE_BITS = (INDEX_BITS > 16) ? INDEX_BITS : 16;
   localparam logic [CAP_BITS-1:0] RESET_CAP =
      CAP_BITS'(drrs_pkg::RESET_STEP_LENGTH * (MAX_POINTS_PER_ITEM + 1));

   logic [15:0]           step_ff, step_in;
   logic [15:0]           sens_ff, sens_in;
   logic signed [15:0]    min_ff, min_in;
   logic signed [15:0]    max_ff, max_in;
   logic [CAP_BITS-1:0]   cap_ff, cap_in;
   logic [CAP_BITS-1:0]   cap_prod;

   logic [31:0]           accum_ff, accum_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;
   logic [INDEX_BITS-1:0] run_idx_ff, run_idx_in;
   logic signed [15:0]    run_lvl_ff, run_lvl_in;
   logic                  have_pts_ff, have_pts_in;
   logic signed [15:0]    y_ff;
   logic                  backlog_ff;

   logic [32:0]           sum;
   logic [31:0]           sat;
   logic signed [15:0]    y_low;
   logic signed [15:0]    y_clamp;
   logic [31:0]           diff;
   logic signed [16:0]    dlev;
   logic [16:0]           adlev;
   logic                  seg_hit;
   logic [WIDE_BITS-1:0]  idx_wide;
   logic [WIDE_BITS-1:0]  run_wide;

   // Configuration registers; the backlog threshold tracks the step length.
   assign cap_prod = CAP_BITS'(csr_data) * CAP_BITS'(MAX_POINTS_PER_ITEM + 1);

   always_comb begin
      step_in = step_ff;
      sens_in = sens_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      cap_in  = cap_ff;
      if (csr_write_en) begin
         case (drrs_pkg::reg_index_type'(csr_index))
            drrs_pkg::REG_STEP_LENGTH: begin
               step_in = csr_data;
               cap_in  = cap_prod;
            end
            drrs_pkg::REG_SENSITIVITY: sens_in = csr_data;
            drrs_pkg::REG_MIN_Y:       min_in  = csr_data;
            drrs_pkg::REG_MAX_Y:       max_in  = csr_data;
            default: begin
               step_in = step_ff;
            end
         endcase
      end
   end

   assign sum     = {1'b0, accum_ff} + {17'd0, req_delta_x};
   assign sat     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign y_low   = (req_sample_y < min_ff) ? min_ff : req_sample_y;
   assign y_clamp = (y_low > max_ff) ? max_ff : y_low;

   assign diff          = accum_ff - {16'd0, step_ff};
   assign sts.have_step = (step_ff != 16'd0) && (accum_ff >= {16'd0, step_ff});
   assign sts.last      = (cnt_ff == CNT_BITS'(MAX_POINTS_PER_ITEM - 1)) ||
                          (diff < {16'd0, step_ff});

   assign dlev    = {y_ff[15], y_ff} - {run_lvl_ff[15], run_lvl_ff};
   assign adlev   = dlev[16] ? 17'(-dlev) : 17'(dlev);
   assign seg_hit = have_pts_ff && (sens_ff != 16'd0) && (adlev > {1'b0, sens_ff});

   assign idx_wide = WIDE_BITS'(count_ff);
   assign run_wide = WIDE_BITS'(run_idx_ff);

   always_comb begin
      accum_in    = accum_ff;
      cnt_in      = cnt_ff;
      count_in    = count_ff;
      run_idx_in  = run_idx_ff;
      run_lvl_in  = run_lvl_ff;
      have_pts_in = have_pts_ff;
      if (cmd.load_item) begin
         accum_in = sat;
         cnt_in   = '0;
      end else if (cmd.emit) begin
         accum_in    = diff;
         cnt_in      = cnt_ff + 1'b1;
         count_in    = count_ff + 1'b1;
         have_pts_in = 1'b1;
         if (!have_pts_ff || seg_hit) begin
            run_idx_in = count_ff;
            run_lvl_in = y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= drrs_pkg::RESET_STEP_LENGTH;
         sens_ff     <= drrs_pkg::RESET_SENSITIVITY;
         min_ff      <= drrs_pkg::RESET_MIN_Y;
         max_ff      <= drrs_pkg::RESET_MAX_Y;
         cap_ff      <= RESET_CAP;
         accum_ff    <= '0;
         cnt_ff      <= '0;
         count_ff    <= '0;
         run_idx_ff  <= '0;
         run_lvl_ff  <= '0;
         have_pts_ff <= 1'b0;
      end else begin
         step_ff     <= step_in;
         sens_ff     <= sens_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         cap_ff      <= cap_in;
         accum_ff    <= accum_in;
         cnt_ff      <= cnt_in;
         count_ff    <= count_in;
         run_idx_ff  <= run_idx_in;
         run_lvl_ff  <= run_lvl_in;
         have_pts_ff <= have_pts_in;
      end
   end

   // Item and response payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         y_ff       <= y_clamp;
         backlog_ff <= (sat >= 32'(cap_ff));
      end
      if (cmd.emit) begin
         rsp_point_index   <= idx_wide[15:0];
         rsp_point_y       <= y_ff;
         rsp_segment_valid <= seg_hit;
         rsp_segment_start <= seg_hit ? run_wide[15:0] : 16'd0;
         rsp_segment_end   <= seg_hit ? idx_wide[15:0] : 16'd0;
         rsp_segment_level <= seg_hit ? run_lvl_ff : 16'sd0;
         rsp_backlog       <= backlog_ff;
         rsp_last_of_run   <= sts.last;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> cnt_ff < CNT_BITS'(MAX_POINTS_PER_ITEM))
      else $error("more points than the per-request cap");

   a_accum_drops: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> accum_ff < $past(accum_ff))
      else $error("accumulator did not drop by one step after a point");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> count_ff == $past(count_ff) + 1'b1 && have_pts_ff)
      else $error("point index did not advance");

endmodule

[design/distance_resample_run_segmenter_unit.sv]
// Distance resample and run segmenter, top level.
// The first point of a request is loaded from the emit state into the response register.
// A new request is accepted only in the idle state, after the previous one is done;
// the emit loop sends one point per cycle through the single response register while it is free.
// Reset (synchronous, active high) restores register defaults, clears the
// accumulator, point counter and run state, and leaves no point pending.
module distance_resample_run_segmenter_unit #(
   parameter int MAX_POINTS_PER_ITEM = drrs_pkg::MAX_POINTS_DEFAULT,
   parameter int INDEX_BITS          = drrs_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   drrs_req_if.sink                            req,
   drrs_rsp_if.source                          rsp,
   input  logic                                csr_write_en,
   input  logic [drrs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [drrs_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   drrs_pkg::cmd_type    cmd;
   drrs_pkg::status_type sts;

   drrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   drrs_datapath #(
      .MAX_POINTS_PER_ITEM (MAX_POINTS_PER_ITEM),
      .INDEX_BITS          (INDEX_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_delta_x       (req.delta_x),
      .req_sample_y      (req.sample_y),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_point_index   (rsp.point_index),
      .rsp_point_y       (rsp.point_y),
      .rsp_segment_valid (rsp.segment_valid),
      .rsp_segment_start (rsp.segment_start),
      .rsp_segment_end   (rsp.segment_end),
      .rsp_segment_level (rsp.segment_level),
      .rsp_backlog       (rsp.backlog),
      .rsp_last_of_run   (rsp.last_of_run)
   );

endmodule
